/* src/sqmf_pkg.sv */
// Shared constants and helpers for the square window median filter.
package sqmf_pkg;

	localparam int PIX_W       = 8;
	localparam int CMD_W       = 1;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MAX_RADIUS  = 3;
	localparam int RING        = 2 * MAX_RADIUS + 1;
	localparam int WIN         = RING * RING;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int SLOT_W      = $clog2(RING);
	localparam int WREG_W      = 11;
	localparam int HREG_W      = 13;
	localparam int RAD_W       = 2;
	localparam int LAG_W       = 12;
	localparam int RANK_W      = $clog2(WIN / 2 + 1);
	localparam int CNT_W       = $clog2(WIN + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	// Zero-based rank of the median among the (2r+1)^2 window samples.
	function automatic logic [RANK_W-1:0] med_rank(input logic [RAD_W-1:0] r);
		logic [CNT_W:0] side;
		logic [2*CNT_W+1:0] n;
		begin
			side = (CNT_W+1)'(r) * (CNT_W+1)'(2) + (CNT_W+1)'(1);
			n    = (2*CNT_W+2)'(side) * (2*CNT_W+2)'(side);
			med_rank = RANK_W'(n >> 1);
		end
	endfunction

endpackage

/* src/square_window_median_filter.sv */
// Streaming median filter over a square window of up to 7x7 pixels.
//
//  channel  | direction | handshake            | word contents
//  ---------+-----------+----------------------+-------------------------------
//  s_*      | in        | s_tvalid / s_tready  | tdata: pixel_in; tuser: command
//  m_*      | out       | m_tvalid / m_tready  | tdata: pixel_out; tlast: frame_last
//  cfg_*    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (write only)
//
// The block takes one word per clock unless stalled and gives at most one word per
// word taken. A word passes through the row store read, the window shift, the load
// of the median stages and eight bit-wise selection stages, one bit per stage. The
// seven row banks, read at one column per cycle unless stalled, set the rate.
// Reset clears all counters and the pipeline; no clearing pass over the row store
// is needed. The whole pipeline stalls only when the two-word output buffer is full.
module square_window_median_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sqmf_pkg::PIX_W-1:0]          s_tdata,   // [7:0] pixel_in
	input  logic [sqmf_pkg::CMD_W-1:0]          s_tuser,   // [0] command
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sqmf_pkg::PIX_W-1:0]          m_tdata,   // [7:0] pixel_out
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sqmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sqmf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sqmf_pkg::*;

	// Configuration registers.
	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [RAD_W-1:0]  radius_q;

	// Frame position counters.
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic              in_done_q;
	logic [LAG_W-1:0]  pend_q;

	logic [WREG_W-1:0] w_eff;
	logic [HREG_W-1:0] h_eff;
	logic [RAD_W-1:0]  r_eff;
	logic [HREG_W-1:0] rw_prod;
	logic [LAG_W-1:0]  lag;

	logic en, acc, cfg_wr, is_pix, is_fl, emit, use_med, last;
	logic in_col_end, in_row_end, out_col_end, out_row_end;

	function automatic logic [SLOT_W-1:0] ring_sub(input logic [SLOT_W-1:0] slot, input int k);
		begin
			if (int'(slot) >= k) begin
				ring_sub = SLOT_W'(int'(slot) - k);
			end else begin
				ring_sub = SLOT_W'(int'(slot) + RING - k);
			end
		end
	endfunction

	// Out-of-range register values are clamped to the supported range.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WREG_W'(1);
		end else if (width_q > WREG_W'(MAX_WIDTH)) begin
			w_eff = WREG_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = HREG_W'(1);
		end else if (height_q > HREG_W'(MAX_HEIGHT)) begin
			h_eff = HREG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		if (radius_q > RAD_W'(MAX_RADIUS)) begin
			r_eff = RAD_W'(MAX_RADIUS);
		end else begin
			r_eff = radius_q;
		end
	end

	// Output runs r*width+r pixels behind the input.
	assign rw_prod = HREG_W'(r_eff) * HREG_W'(w_eff);
	assign lag     = LAG_W'(rw_prod + HREG_W'(r_eff));

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign s_tready  = en;
	assign acc       = s_tvalid && s_tready;

	// A pixel after the frame's last input is dropped; a flush only counts once the
	// whole frame is in. While pixels stream, output starts once the lag is covered.
	assign is_pix = acc && (s_tuser == CMD_PIXEL) && !in_done_q;
	assign is_fl  = acc && (s_tuser == CMD_FLUSH) && in_done_q;
	assign emit   = is_fl || (is_pix && (pend_q >= lag));

	assign in_col_end  = (WREG_W'(in_col_q) + WREG_W'(1)) >= w_eff;
	assign in_row_end  = (HREG_W'(in_row_q) + HREG_W'(1)) >= h_eff;
	assign out_col_end = (WREG_W'(out_col_q) + WREG_W'(1)) >= w_eff;
	assign out_row_end = (HREG_W'(out_row_q) + HREG_W'(1)) >= h_eff;
	assign last        = emit && out_col_end && out_row_end;

	// The median is only needed for interior pixels. Those always leave on a pixel
	// word, when the newest window column is the pixel just taken in. Flush words
	// drain only border pixels, which pass through.
	assign use_med = is_pix
		&& (HREG_W'(out_row_q) >= HREG_W'(r_eff))
		&& ((HREG_W'(out_row_q) + HREG_W'(r_eff)) < h_eff)
		&& (WREG_W'(out_col_q) >= WREG_W'(r_eff))
		&& ((WREG_W'(out_col_q) + WREG_W'(r_eff)) < w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WREG_W'(1024);
			height_q   <= HREG_W'(1024);
			radius_q   <= RAD_W'(1);
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else if (cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
				|| cfg_index == REG_RADIUS)) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WREG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HREG_W-1:0];
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default:    width_q  <= width_q;
			endcase
			// Any register write restarts the frame.
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else if (last) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else begin
			if (is_pix) begin
				if (in_col_end) begin
					in_col_q <= '0;
					if (in_row_end) begin
						in_row_q  <= '0;
						in_slot_q <= '0;
						in_done_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + ROW_W'(1);
						in_slot_q <= (in_slot_q == SLOT_W'(RING - 1)) ? '0
							: in_slot_q + SLOT_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (emit) begin
				if (out_col_end) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + ROW_W'(1);
					out_slot_q <= (out_slot_q == SLOT_W'(RING - 1)) ? '0
						: out_slot_q + SLOT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
			pend_q <= pend_q + LAG_W'(is_pix) - LAG_W'(emit);
		end
	end

	// Row store: one bank per ring row. A pixel word writes its own row's bank and
	// reads the same column from every bank; a flush word reads the pixel to drain.
	logic [PIX_W-1:0] rd_c [RING];
	logic [COL_W-1:0] rd_addr;

	assign rd_addr = is_pix ? in_col_q : out_col_q;

	for (genvar b = 0; b < RING; b++) begin : g_bank
		sqmf_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_WIDTH)
		) u_bank (
			.clk  (clk),
			.we   (is_pix && (in_slot_q == SLOT_W'(b))),
			.waddr(in_col_q),
			.wdata(s_tdata),
			.re   (en),
			.raddr(rd_addr),
			.rdata(rd_c[b])
		);
	end

	// Stage 1: row store data arrives.
	logic              pix_s1, emit_s1, med_s1, last_s1, fl_s1;
	logic [PIX_W-1:0]  data_s1;
	logic [SLOT_W-1:0] islot_s1, oslot_s1;

	// Stage 2: window holds this word's neighborhood.
	logic              emit_s2, med_s2, last_s2, fl_s2;
	logic [PIX_W-1:0]  flv_s2;

	logic [PIX_W-1:0]  col_c [RING];
	logic [PIX_W-1:0]  win_q [RING][RING];

	// Median selection stages: one result bit per stage, most significant first.
	logic [PIX_W-1:0]  med_smp_q  [PIX_W][WIN];
	logic [WIN-1:0]    med_mask_q [PIX_W];
	logic [RANK_W-1:0] med_rank_q [PIX_W];
	logic [PIX_W-1:0]  med_res_q  [PIX_W+1];
	logic [PIX_W-1:0]  med_pass_q [PIX_W+1];
	logic              med_emit_q [PIX_W+1];
	logic              med_use_q  [PIX_W+1];
	logic              med_last_q [PIX_W+1];

	logic [CNT_W-1:0]  cnt_c   [PIX_W];
	logic [WIN-1:0]    nmask_c [PIX_W];
	logic [RANK_W-1:0] nrank_c [PIX_W];
	logic [PIX_W-1:0]  nres_c  [PIX_W];

	// The newest column: this word's pixel on the bottom row, older rows above it.
	always_comb begin
		col_c[0] = data_s1;
		for (int k = 1; k < RING; k++) begin
			col_c[k] = rd_c[ring_sub(islot_s1, k)];
		end
	end

	// Each stage counts the remaining candidates with a zero in its bit and keeps
	// the half that holds the wanted rank.
	always_comb begin
		for (int j = 0; j < PIX_W; j++) begin
			cnt_c[j] = '0;
			for (int i = 0; i < WIN; i++) begin
				if (med_mask_q[j][i] && !med_smp_q[j][i][PIX_W-1-j]) begin
					cnt_c[j] = cnt_c[j] + CNT_W'(1);
				end
			end
			nres_c[j] = med_res_q[j];
			if (CNT_W'(med_rank_q[j]) < cnt_c[j]) begin
				nrank_c[j] = med_rank_q[j];
				for (int i = 0; i < WIN; i++) begin
					nmask_c[j][i] = med_mask_q[j][i] && !med_smp_q[j][i][PIX_W-1-j];
				end
			end else begin
				nres_c[j][PIX_W-1-j] = 1'b1;
				nrank_c[j] = med_rank_q[j] - RANK_W'(cnt_c[j]);
				for (int i = 0; i < WIN; i++) begin
					nmask_c[j][i] = med_mask_q[j][i] && med_smp_q[j][i][PIX_W-1-j];
				end
			end
		end
	end

	// Two-word output buffer.
	logic [PIX_W-1:0] ob_pix_q  [2];
	logic             ob_last_q [2];
	logic             ob_wr_q, ob_rd_q;
	logic [1:0]       ob_cnt_q;
	logic             push, pop;
	logic [PIX_W-1:0] fin_pix;

	assign en      = (ob_cnt_q != 2'd2);
	assign fin_pix = med_use_q[PIX_W] ? med_res_q[PIX_W] : med_pass_q[PIX_W];
	assign push    = en && med_emit_q[PIX_W];
	assign pop     = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1  <= 1'b0;
			emit_s1 <= 1'b0;
			fl_s1   <= 1'b0;
			emit_s2 <= 1'b0;
			for (int j = 0; j <= PIX_W; j++) begin
				med_emit_q[j] <= 1'b0;
			end
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			if (en) begin
				pix_s1  <= is_pix;
				emit_s1 <= emit;
				fl_s1   <= is_fl;
				emit_s2 <= emit_s1;
				med_emit_q[0] <= emit_s2;
				for (int j = 0; j < PIX_W; j++) begin
					med_emit_q[j+1] <= med_emit_q[j];
				end
			end
			if (push) begin
				ob_wr_q <= ~ob_wr_q;
			end
			if (pop) begin
				ob_rd_q <= ~ob_rd_q;
			end
			ob_cnt_q <= ob_cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			med_s1   <= use_med;
			last_s1  <= last;
			data_s1  <= s_tdata;
			islot_s1 <= in_slot_q;
			oslot_s1 <= out_slot_q;

			med_s2  <= med_s1;
			last_s2 <= last_s1;
			fl_s2   <= fl_s1;
			flv_s2  <= rd_c[oslot_s1];

			if (pix_s1) begin
				win_q[0] <= col_c;
				for (int c = 1; c < RING; c++) begin
					win_q[c] <= win_q[c-1];
				end
			end

			// Border pixels on pixel words come from the window center r columns
			// and r rows back.
			for (int c = 0; c < RING; c++) begin
				for (int k = 0; k < RING; k++) begin
					med_smp_q[0][c*RING+k] <= win_q[c][k];
					med_mask_q[0][c*RING+k] <= (c <= 2 * int'(r_eff))
						&& (k <= 2 * int'(r_eff));
				end
			end
			med_rank_q[0] <= med_rank(r_eff);
			med_res_q[0]  <= '0;
			med_pass_q[0] <= fl_s2 ? flv_s2 : win_q[SLOT_W'(r_eff)][SLOT_W'(r_eff)];
			med_use_q[0]  <= med_s2;
			med_last_q[0] <= last_s2;

			for (int j = 0; j < PIX_W; j++) begin
				med_res_q[j+1]  <= nres_c[j];
				med_pass_q[j+1] <= med_pass_q[j];
				med_use_q[j+1]  <= med_use_q[j];
				med_last_q[j+1] <= med_last_q[j];
			end
			for (int j = 0; j < PIX_W - 1; j++) begin
				med_smp_q[j+1]  <= med_smp_q[j];
				med_mask_q[j+1] <= nmask_c[j];
				med_rank_q[j+1] <= nrank_c[j];
			end
		end
		if (push) begin
			ob_pix_q[ob_wr_q]  <= fin_pix;
			ob_last_q[ob_wr_q] <= med_last_q[PIX_W];
		end
	end

	assign m_tvalid = (ob_cnt_q != 2'd0);
	assign m_tdata  = ob_pix_q[ob_rd_q];
	assign m_tlast  = ob_last_q[ob_rd_q];

	// The last stage's mask and rank are not needed once its bit is decided.
	logic unused_tail;
	assign unused_tail = ^{nmask_c[PIX_W-1], nrank_c[PIX_W-1]};
endmodule

/* src/sqmf_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module sqmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
